/* rtl/assert_macros.svh */
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, switched off while reset is held
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// concurrent assertion that is also checked during reset
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

/* rtl/scrlp_pkg.sv */
// shared types, constants and functions for the cigar run-length packer
// no dependencies
`timescale 1ns / 1ps

package scrlp_pkg;

  // run length field width
  localparam int unsigned LenBits  = 28;
  localparam int unsigned WordBits = 32;
  localparam int unsigned CodeBits = 4;

  // word queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  // configuration port
  localparam int unsigned AddrW = 3;
  localparam logic [AddrW-1:0] AddrMismatchMode = AddrW'(0);

  localparam logic [LenBits-1:0] LenMax = {LenBits{1'b1}};

  // ascii characters
  localparam logic [7:0] ChrM  = 8'h4d;
  localparam logic [7:0] ChrI  = 8'h49;
  localparam logic [7:0] ChrD  = 8'h44;
  localparam logic [7:0] ChrN  = 8'h4e;
  localparam logic [7:0] ChrEq = 8'h3d;
  localparam logic [7:0] ChrX  = 8'h58;

  // sam operation codes
  typedef enum logic [CodeBits-1:0] {
    CODE_M   = 4'd0,
    CODE_I   = 4'd1,
    CODE_D   = 4'd2,
    CODE_N   = 4'd3,
    CODE_EQ  = 4'd7,
    CODE_X   = 4'd8,
    CODE_UNK = 4'd15
  } op_code_e;

  typedef struct packed {
    logic [7:0] op_char;
    logic       final_op;
  } in_item_t;

  typedef struct packed {
    logic [WordBits-1:0] packed_word;
    logic                last_word;
  } out_item_t;

  // front to queue: number of words this beat and the words themselves
  typedef struct packed {
    logic [1:0]      count;
    out_item_t [1:0] item;
  } qwr_t;

  function automatic op_code_e op_code(input logic [7:0] c, input logic mismatch);
    op_code_e code;
    case (c)
      ChrM:    code = mismatch ? CODE_EQ : CODE_M;
      ChrI:    code = CODE_I;
      ChrD:    code = CODE_D;
      ChrN:    code = CODE_N;
      ChrEq:   code = CODE_EQ;
      ChrX:    code = CODE_X;
      default: code = CODE_UNK;
    endcase
    return code;
  endfunction

  function automatic logic [WordBits-1:0] pack_run(input logic [7:0] c,
                                                   input logic [LenBits-1:0] len,
                                                   input logic mismatch);
    logic [WordBits-1:0] w;
    w = (WordBits'(len) << CodeBits) | WordBits'(op_code(c, mismatch));
    return w;
  endfunction

endpackage

/* rtl/scrlp_front.sv */
// front end: folds characters, tracks the open run, builds cigar words
// depends on scrlp_pkg
`timescale 1ns / 1ps

module scrlp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  scrlp_pkg::in_item_t item_i,
  input  logic                mismatch_i,
  output scrlp_pkg::qwr_t     wr_o
);
  import scrlp_pkg::*;

  logic [7:0]         run_op_q, run_op_d;
  logic [LenBits-1:0] run_len_q, run_len_d;
  logic               run_open_q, run_open_d;

  logic [7:0]         chr;
  logic               same;
  logic               emit_old;
  logic [LenBits-1:0] len_new;
  out_item_t          old_word, fin_word;

  // fold x into m outside mismatch mode, then classify against the open run
  always_comb begin
    chr = (!mismatch_i && item_i.op_char == ChrX) ? ChrM : item_i.op_char;
    same = run_open_q && (chr == run_op_q);
    emit_old = run_open_q && !same;
    if (same) begin
      len_new = (run_len_q == LenMax) ? run_len_q : run_len_q + LenBits'(1);
    end else begin
      len_new = LenBits'(1);
    end
    old_word.packed_word = pack_run(run_op_q, run_len_q, mismatch_i);
    old_word.last_word   = 1'b0;
    fin_word.packed_word = pack_run(chr, len_new, mismatch_i);
    fin_word.last_word   = 1'b1;
  end

  // words handed to the queue this beat
  always_comb begin
    wr_o.count = 2'd0;
    wr_o.item  = {old_word, fin_word};
    if (accept_i) begin
      wr_o.count = {1'b0, emit_old} + {1'b0, item_i.final_op};
    end
    if (emit_old) begin
      wr_o.item[0] = old_word;
      wr_o.item[1] = fin_word;
    end else begin
      wr_o.item[0] = fin_word;
      wr_o.item[1] = old_word;
    end
  end

  // run state update, closed again by a final beat
  always_comb begin
    run_op_d   = run_op_q;
    run_len_d  = run_len_q;
    run_open_d = run_open_q;
    if (accept_i) begin
      if (item_i.final_op) begin
        run_op_d   = 8'd0;
        run_len_d  = '0;
        run_open_d = 1'b0;
      end else begin
        run_op_d   = chr;
        run_len_d  = len_new;
        run_open_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_op_q   <= 8'd0;
      run_len_q  <= '0;
      run_open_q <= 1'b0;
    end else begin
      run_op_q   <= run_op_d;
      run_len_q  <= run_len_d;
      run_open_q <= run_open_d;
    end
  end

endmodule

/* rtl/scrlp_queue.sv */
// word queue: up to two writes and one read per cycle
// depends on scrlp_pkg
`timescale 1ns / 1ps

module scrlp_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  scrlp_pkg::qwr_t      wr_i,
  input  logic                 rd_i,
  output scrlp_pkg::out_item_t rd_item_o,
  output logic                 empty_o,
  output logic                 full_o
);
  import scrlp_pkg::*;

  out_item_t        entries_q [QDepth];
  logic [QPtrW-1:0] wptr_q, wptr_d;
  logic [QPtrW-1:0] rptr_q, rptr_d;
  logic [QPtrW:0]   count_q, count_d;

  // pointer and fill bookkeeping
  always_comb begin
    wptr_d  = wptr_q + QPtrW'(wr_i.count);
    rptr_d  = rptr_q + QPtrW'(rd_i);
    count_d = count_q + (QPtrW+1)'(wr_i.count) - (QPtrW+1)'(rd_i);
  end

  assign empty_o   = (count_q == '0);
  // full unless two slots are free, so a two-word beat always fits
  assign full_o    = (count_q > (QPtrW+1)'(QDepth - 2));
  assign rd_item_o = entries_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_i.count != 2'd0) begin
      entries_q[wptr_q] <= wr_i.item[0];
    end
    if (wr_i.count == 2'd2) begin
      entries_q[wptr_q + QPtrW'(1)] <= wr_i.item[1];
    end
  end

endmodule

/* rtl/scrlp_back.sv */
// back end: output register that presents the oldest word and takes pops
// depends on scrlp_pkg
`timescale 1ns / 1ps

module scrlp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  scrlp_pkg::out_item_t q_item_i,
  input  logic                 q_empty_i,
  output logic                 q_rd_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output scrlp_pkg::out_item_t out_item_o
);
  import scrlp_pkg::*;

  logic      valid_q, valid_d;
  out_item_t item_q;
  logic      load;

  // refill whenever the register is free or being drained
  always_comb begin
    load    = !q_empty_i && (!valid_q || pop_i);
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  assign q_rd_o     = load;
  assign empty_o    = !valid_q;
  assign out_item_o = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= q_item_i;
    end
  end

endmodule

/* rtl/sam_cigar_run_length_packer_unit.sv */
// a word that closes a run is written into the queue with its beat and reaches the
// result ports from the output register once that register is free
// throughput: one operation per cycle unless full; a final beat may add a second word
// the four-entry word queue raises full once fewer than two slots are free
// results drain at one word per cycle through the output register while pop is high
// reset (asynchronous, active low) drops any open run, empties the queue, clears mode
`timescale 1ns / 1ps

module sam_cigar_run_length_packer_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // operation input
  input  logic                              push,
  output logic                              full,
  input  scrlp_pkg::in_item_t               in_item_i,
  // cigar word output
  output logic                              empty,
  input  logic                              pop,
  output scrlp_pkg::out_item_t              out_item_o,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [scrlp_pkg::AddrW-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import scrlp_pkg::*;

  logic      mismatch_q, mismatch_d;
  logic      accept;
  qwr_t      qwr;
  out_item_t q_item;
  logic      q_empty;
  logic      q_rd;

  // configuration register
  assign pready = 1'b1;

  always_comb begin
    mismatch_d = mismatch_q;
    if (psel && penable && pwrite && pready && paddr == AddrMismatchMode) begin
      mismatch_d = pwdata[0];
    end
    prdata = (paddr == AddrMismatchMode) ? {31'd0, mismatch_q} : 32'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mismatch_q <= 1'b0;
    end else begin
      mismatch_q <= mismatch_d;
    end
  end

  assign accept = push && !full;

  scrlp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (in_item_i),
    .mismatch_i (mismatch_q),
    .wr_o       (qwr)
  );

  scrlp_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (qwr),
    .rd_i      (q_rd),
    .rd_item_o (q_item),
    .empty_o   (q_empty),
    .full_o    (full)
  );

  scrlp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_item_i   (q_item),
    .q_empty_i  (q_empty),
    .q_rd_o     (q_rd),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_item_o (out_item_o)
  );

endmodule

/* rtl/scrlp_checker.sv */
// port-level checks for the cigar run-length packer, bound to the top level
// depends on scrlp_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scrlp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        push,
  input logic                        full,
  input scrlp_pkg::in_item_t         in_item_i,
  input logic                        empty,
  input logic                        pop,
  input scrlp_pkg::out_item_t        out_item_o,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [scrlp_pkg::AddrW-1:0] paddr,
  input logic [31:0]                 pwdata,
  input logic [31:0]                 prdata
);
  import scrlp_pkg::*;

  // a waiting word holds until popped
  `ASSERT_RST(a_out_hold, clk_i, rst_ni, (!empty && !pop) |=> (!empty && $stable(out_item_o)))

  // an accepted final beat always leads to a word on the ports, via the queue and output register
  `ASSERT_RST(a_final_word, clk_i, rst_ni, (push && !full && in_item_i.final_op) |-> ##2 !empty)

  // the mode register reads back what was written
  `ASSERT_RST(a_mode_readback, clk_i, rst_ni, (psel && penable && pwrite && paddr == AddrMismatchMode) |=> (paddr != AddrMismatchMode || prdata[0] == $past(pwdata[0])))

  // nothing is presented while reset is held
  `ASSERT_ALWAYS(a_reset_empty, clk_i, (!rst_ni) |-> empty)

endmodule

bind sam_cigar_run_length_packer_unit scrlp_checker u_scrlp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push       (push),
  .full       (full),
  .in_item_i  (in_item_i),
  .empty      (empty),
  .pop        (pop),
  .out_item_o (out_item_o),
  .psel       (psel),
  .penable    (penable),
  .pwrite     (pwrite),
  .paddr      (paddr),
  .pwdata     (pwdata),
  .prdata     (prdata)
);
